@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both assume a clock named clk and an
// active-low reset named rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/mpp_pkg.sv @@
package mpp_pkg;

    localparam int F_W      = 13;   // focal length register
    localparam int C_W      = 16;   // center offsets
    localparam int MP_W     = 12;   // max_pairs
    localparam int IDX_W    = 13;   // point index
    localparam int POS_W    = 13;   // walk position
    localparam int DEC_W    = 32;   // decision variable
    localparam int SQ_W     = 26;   // running square of the x position
    localparam int PROD_W   = 26;   // |f| * y
    localparam int SUM_W    = 18;   // exact coordinate after the center offset
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    localparam logic [CFG_A_W-1:0] REG_FOCUS        = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_CENTER_X     = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_CENTER_Y     = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_MAX_PAIRS    = 2'd3;

    typedef struct packed {
        logic [F_W-1:0]        mag_f;      // magnitude of the focal length, 4096 included
        logic                  mirrored;
        logic signed [C_W-1:0] center_x;
        logic signed [C_W-1:0] center_y;
        logic [MP_W-1:0]       max_pairs;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic                    last;
        logic                    exhausted;
    } res_t;

endpackage

@@ hdl/mpp_req_if.sv @@
interface mpp_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

@@ hdl/mpp_pt_if.sv @@
interface mpp_pt_if #(
    parameter int COORD_BITS = 17
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
    logic                         exhausted;

    modport source (output valid, output point_x, output point_y, output last_point,
                    output exhausted, input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  input exhausted, output ready);
endinterface

@@ hdl/mpp_cfg.sv @@
module mpp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mpp_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [mpp_pkg::CFG_D_W-1:0] cfg_data,
    output mpp_pkg::cfg_t               cfg
);

    logic signed [mpp_pkg::F_W-1:0]  focal_reg;
    logic signed [mpp_pkg::C_W-1:0]  center_x_reg;
    logic signed [mpp_pkg::C_W-1:0]  center_y_reg;
    logic [mpp_pkg::MP_W-1:0]        max_pairs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg     <= mpp_pkg::F_W'(1);
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            max_pairs_reg <= mpp_pkg::MP_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpp_pkg::REG_FOCUS:        focal_reg     <= cfg_data[mpp_pkg::F_W-1:0];
                mpp_pkg::REG_CENTER_X:     center_x_reg  <= cfg_data;
                mpp_pkg::REG_CENTER_Y:     center_y_reg  <= cfg_data;
                mpp_pkg::REG_MAX_PAIRS:    max_pairs_reg <= cfg_data[mpp_pkg::MP_W-1:0];
                default:                   focal_reg     <= focal_reg;
            endcase
        end
    end

    // The two's complement negation of -4096 is 0x1000, read unsigned as 4096.
    always_comb
    begin
        cfg.mirrored  = focal_reg[mpp_pkg::F_W-1];
        cfg.mag_f     = focal_reg[mpp_pkg::F_W-1] ? (~focal_reg + mpp_pkg::F_W'(1)) : focal_reg;
        cfg.center_x  = center_x_reg;
        cfg.center_y  = center_y_reg;
        cfg.max_pairs = max_pairs_reg;
    end

endmodule

@@ hdl/mpp_walk.sv @@
`include "assert_macros.svh"

module mpp_walk (
    input  logic          clk,
    input  logic          rst_n,
    input  mpp_pkg::cfg_t cfg,
    input  logic          step_en,
    input  logic          restart,
    output mpp_pkg::res_t res
);

    logic [mpp_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [mpp_pkg::POS_W-1:0]        x_reg, x_next;
    logic [mpp_pkg::POS_W-1:0]        y_reg, y_next;
    logic signed [mpp_pkg::DEC_W-1:0] dec_reg, dec_next;
    logic [mpp_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic                             r2_reg, r2_next;

    logic [mpp_pkg::IDX_W-1:0]        idx_eff;
    logic [mpp_pkg::IDX_W-1:0]        count;
    logic [mpp_pkg::IDX_W-1:0]        last_idx;
    logic                             exh;
    logic                             apex;
    logic                             in_r1;
    logic [mpp_pkg::F_W+1:0]          r1_lim;
    logic [mpp_pkg::POS_W-1:0]        x_inc;
    logic signed [mpp_pkg::DEC_W-1:0] four_f;
    logic signed [mpp_pkg::DEC_W-1:0] twox1;
    logic [mpp_pkg::PROD_W-1:0]       prod;
    logic signed [mpp_pkg::DEC_W-1:0] seed;
    logic signed [mpp_pkg::DEC_W-1:0] d_s;
    logic signed [mpp_pkg::DEC_W-1:0] d_a;
    logic [mpp_pkg::SQ_W-1:0]         sq_inc;
    logic                             dec_pos;
    logic signed [mpp_pkg::SUM_W-1:0] ux;
    logic signed [mpp_pkg::SUM_W-1:0] uy;
    logic signed [mpp_pkg::SUM_W-1:0] cx;
    logic signed [mpp_pkg::SUM_W-1:0] cy;

    always_comb
    begin
        idx_eff  = restart ? '0 : idx_reg;
        count    = {cfg.max_pairs, 1'b1};
        last_idx = {cfg.max_pairs, 1'b0};
        exh      = (idx_eff >= count);
        apex     = (idx_eff == '0);
        r1_lim   = {cfg.mag_f, 2'b01};
        in_r1    = !r2_reg && ({2'b00, idx_eff} < r1_lim);
        x_inc    = x_reg + mpp_pkg::POS_W'(1);
        four_f   = signed'(mpp_pkg::DEC_W'({cfg.mag_f, 2'b00}));
        twox1    = signed'(mpp_pkg::DEC_W'({x_inc, 1'b1}));
        sq_inc   = sq_reg + mpp_pkg::SQ_W'({x_reg, 1'b1});
        dec_pos  = !dec_reg[mpp_pkg::DEC_W-1] && (dec_reg != '0);

        // Region 2 reseeds from x*x - 4|f|*y; x*x is kept as a running square.
        prod = mpp_pkg::PROD_W'(cfg.mag_f) * mpp_pkg::PROD_W'(y_reg);
        seed = signed'(mpp_pkg::DEC_W'(sq_reg)) - signed'(mpp_pkg::DEC_W'({prod, 2'b00}));
        d_s  = r2_reg ? dec_reg : seed;
        d_a  = dec_pos ? (dec_reg - four_f) : dec_reg;

        idx_next = idx_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        dec_next = dec_reg;
        sq_next  = sq_reg;
        r2_next  = r2_reg;

        if (!exh)
        begin
            idx_next = idx_eff + mpp_pkg::IDX_W'(1);
            if (apex)
            begin
                x_next   = '0;
                y_next   = '0;
                sq_next  = '0;
                r2_next  = 1'b0;
                dec_next = signed'(mpp_pkg::DEC_W'(1))
                         - signed'(mpp_pkg::DEC_W'({cfg.mag_f, 1'b0}));
            end
            else if (idx_eff[0])
            begin
                if (in_r1)
                begin
                    x_next   = x_inc;
                    sq_next  = sq_inc;
                    y_next   = dec_pos ? (y_reg + mpp_pkg::POS_W'(1)) : y_reg;
                    dec_next = d_a + twox1;
                end
                else
                begin
                    r2_next = 1'b1;
                    y_next  = y_reg + mpp_pkg::POS_W'(1);
                    if (d_s[mpp_pkg::DEC_W-1])
                    begin
                        x_next   = x_inc;
                        sq_next  = sq_inc;
                        dec_next = d_s + twox1 - four_f;
                    end
                    else
                    begin
                        dec_next = d_s - four_f;
                    end
                end
            end
        end

        // The odd point shows the advanced walk, the even point its mirror in x.
        ux = signed'(mpp_pkg::SUM_W'(x_next));
        uy = signed'(mpp_pkg::SUM_W'(y_next));
        cx = mpp_pkg::SUM_W'(cfg.center_x);
        cy = mpp_pkg::SUM_W'(cfg.center_y);

        res.exhausted = exh;
        res.last      = !exh && (idx_eff == last_idx);
        if (exh)
        begin
            res.sum_x = '0;
            res.sum_y = '0;
        end
        else
        begin
            res.sum_x = (!apex && !idx_eff[0]) ? (cx - ux) : (cx + ux);
            res.sum_y = cfg.mirrored ? (cy - uy) : (cy + uy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
            dec_reg <= '0;
            sq_reg  <= '0;
            r2_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            idx_reg <= idx_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            dec_reg <= dec_next;
            sq_reg  <= sq_next;
            r2_reg  <= r2_next;
        end
    end

    // The walk moves at most one step per point, so neither coordinate can pass the index.
    `ASSERT_SAME(a_x_bound, 1'b1, x_reg <= idx_reg)
    `ASSERT_SAME(a_y_bound, 1'b1, y_reg <= idx_reg)
    `ASSERT_NEXT(a_apex_seed, step_en && (restart || idx_reg == '0),
                 x_reg == '0 && y_reg == '0 && sq_reg == '0 && !r2_reg)

endmodule

@@ hdl/midpoint_parabola_points.sv @@
// An accepted request beat is walked from the request register into the output register.
// Throughput: one request and one point per cycle while pt.ready is high; the decision update
// closes through its register alone. The output register and the request register let a new
// request in while a point waits. Reset (rst_n, asynchronous, active low) empties both stages,
// rewinds the list to the apex, and loads a focal length of 1, center 0 and max_pairs 100.
`include "assert_macros.svh"

module midpoint_parabola_points #(
    parameter int COORD_BITS = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mpp_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [mpp_pkg::CFG_D_W-1:0] cfg_data,
    mpp_req_if.sink                     req,
    mpp_pt_if.source                    pt
);

    // The block is a two-stage pipeline. The first stage only captures the request
    // beat. The second stage runs one step of the midpoint walk from the held request
    // and the walk state, and loads the finished point into the output register. The
    // walk state advances exactly when a request leaves the first stage, so requests
    // are served strictly in order without gaps.

    mpp_pkg::cfg_t cfg;
    mpp_pkg::res_t res;

    logic                         s1_valid_reg;
    logic                         s1_restart_reg;
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic                         out_last_reg;
    logic                         out_exh_reg;

    logic out_load;
    logic s1_adv;
    logic req_take;

    mpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpp_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (s1_adv),
        .restart (s1_restart_reg),
        .res     (res)
    );

    // The output register takes a new point when it is empty or its beat is being taken.
    assign out_load  = !out_valid_reg || pt.ready;
    assign s1_adv    = s1_valid_reg && out_load;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_take  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers carry no reset; they are only looked at under their valid bits.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_restart_reg <= req.restart;
        end
        if (s1_adv)
        begin
            // The exact coordinate is wrapped or sign-extended to the port width.
            out_x_reg    <= COORD_BITS'(res.sum_x);
            out_y_reg    <= COORD_BITS'(res.sum_y);
            out_last_reg <= res.last;
            out_exh_reg  <= res.exhausted;
        end
    end

    assign pt.valid      = out_valid_reg;
    assign pt.point_x    = out_x_reg;
    assign pt.point_y    = out_y_reg;
    assign pt.last_point = out_last_reg;
    assign pt.exhausted  = out_exh_reg;

    // A request held in the first stage must not be overwritten while the output stalls.
    `ASSERT_SAME(a_no_overrun, s1_valid_reg && out_valid_reg && !pt.ready, !req.ready)
    // A request that leaves the first stage always shows up as a point next cycle.
    `ASSERT_NEXT(a_load, s1_adv, out_valid_reg)
    // A beat past the list end carries no coordinates and is never the last point.
    `ASSERT_SAME(a_exh_zero, out_valid_reg && out_exh_reg,
                 out_x_reg == '0 && out_y_reg == '0 && !out_last_reg)

endmodule

@@ dv/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 17;
    // Longest legal stretch without any beat is the long receiver hold-off
    // plus a drain and a register update, all well below this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 64;

    // One expected point beat, laid out like the output channel.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic                         exhausted;
    } point_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [mpp_pkg::CFG_A_W-1:0]  cfg_index;
    logic [mpp_pkg::CFG_D_W-1:0]  cfg_data;

    mpp_req_if                            req_ch ();
    mpp_pt_if #(.COORD_BITS(COORD_BITS))  pt_ch ();

    midpoint_parabola_points #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .pt        (pt_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the registers, updated at the edge that writes them.
    logic signed [mpp_pkg::F_W-1:0]  cfg_focal;
    logic signed [mpp_pkg::C_W-1:0]  cfg_cx;
    logic signed [mpp_pkg::C_W-1:0]  cfg_cy;
    logic [mpp_pkg::MP_W-1:0]        cfg_pairs;

    // Shadow copy of the walk. walk_steep is set once the walk has left
    // the shallow part of the curve (x steps every time) for the steep part
    // (y steps every time).
    logic [mpp_pkg::POS_W-1:0]        walk_x;
    logic [mpp_pkg::POS_W-1:0]        walk_y;
    logic signed [mpp_pkg::DEC_W-1:0] walk_dec;
    logic [mpp_pkg::IDX_W-1:0]        walk_idx;
    bit                               walk_steep;

    point_t pending_points[$];

    int  mismatch_count = 0;
    int  sent_count     = 0;
    int  hold_req       = 0;
    int  idle_cycles    = 0;
    bit  idle_on        = 1'b1;

    task automatic load_reset_state();
        cfg_focal  = 1;
        cfg_cx     = '0;
        cfg_cy     = '0;
        cfg_pairs  = 100;
        walk_x     = '0;
        walk_y     = '0;
        walk_dec   = '0;
        walk_idx   = '0;
        walk_steep = 1'b0;
    endtask

    // Works out the point that one request produces and advances the walk.
    // Every step uses the register values of the moment; the walk itself is
    // never recomputed when a register changes.
    function automatic point_t next_parabola_point(bit restart);
        point_t r;
        bit     flip;
        int     f;
        int     count;
        int     i;
        int     x;
        int     y;
        int     d;
        int     px;
        int     py;
        int     sum;

        flip  = cfg_focal < 0;
        // A focal length of -4096 gives a magnitude of 4096, which int holds.
        f     = flip ? -int'(cfg_focal) : int'(cfg_focal);
        count = 2 * int'(cfg_pairs) + 1;
        r     = '0;

        if (restart)
            walk_idx = '0;
        i = int'(walk_idx);

        // Past the end of the list: zero coordinates, the index stays put.
        if (i >= count)
        begin
            r.exhausted = 1'b1;
            return r;
        end

        x = int'(walk_x);
        y = int'(walk_y);
        d = walk_dec;

        if (i == 0)
        begin
            // The apex also seeds the walk.
            x          = 0;
            y          = 0;
            d          = 1 - 2 * f;
            walk_steep = 1'b0;
            px         = 0;
            py         = 0;
        end
        else if (i[0])
        begin
            if (!walk_steep && i < 4 * f + 1)
            begin
                x = x + 1;
                if (d > 0)
                begin
                    y = y + 1;
                    d = d - 4 * f;
                end
                d = d + 2 * x + 1;
            end
            else
            begin
                // Entering the steep part reseeds the decision; the half
                // pixel offset drops out in integer arithmetic.
                if (!walk_steep)
                begin
                    walk_steep = 1'b1;
                    d          = x * x - 4 * f * y;
                end
                if (d < 0)
                begin
                    x = x + 1;
                    d = d + 2 * x + 1;
                end
                d = d - 4 * f;
                y = y + 1;
            end
            px = x;
            py = y;
        end
        else
        begin
            // Even index: mirror image of the point just emitted.
            px = -x;
            py = y;
        end

        if (flip)
            py = -py;

        sum      = px + int'(cfg_cx);
        r.x      = sum[COORD_BITS-1:0];
        sum      = py + int'(cfg_cy);
        r.y      = sum[COORD_BITS-1:0];
        r.last   = (i == count - 1);

        walk_x   = x[mpp_pkg::POS_W-1:0];
        walk_y   = y[mpp_pkg::POS_W-1:0];
        walk_dec = d;
        walk_idx = mpp_pkg::IDX_W'(i + 1);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one request beat, with an optional random gap in front of it,
    // and records the expected point once the beat is taken.
    task automatic send_request(bit restart);
        int gap;

        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            req_ch.valid   <= 1'b0;
            req_ch.restart <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_points.push_back(next_parabola_point(restart));
        sent_count++;
    endtask

    task automatic end_requests();
        @(negedge clk);
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
    endtask

    // Waits for every expected point, then lets the pipeline settle.
    task automatic wait_drained();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register. Bits above the register's width carry random
    // values, which the block must ignore.
    task automatic write_reg(logic [mpp_pkg::CFG_A_W-1:0] idx, int value, int keep);
        logic [mpp_pkg::CFG_D_W-1:0] mask;
        logic [mpp_pkg::CFG_D_W-1:0] data;

        mask = mpp_pkg::CFG_D_W'((1 << keep) - 1);
        data = (mpp_pkg::CFG_D_W'($urandom) & ~mask) | (mpp_pkg::CFG_D_W'(value) & mask);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            mpp_pkg::REG_FOCUS:     cfg_focal = data[mpp_pkg::F_W-1:0];
            mpp_pkg::REG_CENTER_X:  cfg_cx    = data[mpp_pkg::C_W-1:0];
            mpp_pkg::REG_CENTER_Y:  cfg_cy    = data[mpp_pkg::C_W-1:0];
            mpp_pkg::REG_MAX_PAIRS: cfg_pairs = data[mpp_pkg::MP_W-1:0];
            default:                ;
        endcase
    endtask

    // Registers change only while the block is idle.
    task automatic set_config(int focal, int cx, int cy, int pairs);
        wait_drained();
        write_reg(mpp_pkg::REG_FOCUS, focal, mpp_pkg::F_W);
        write_reg(mpp_pkg::REG_CENTER_X, cx, mpp_pkg::C_W);
        write_reg(mpp_pkg::REG_CENTER_Y, cy, mpp_pkg::C_W);
        write_reg(mpp_pkg::REG_MAX_PAIRS, pairs, mpp_pkg::MP_W);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Walks a list, with an occasional restart thrown in as noise.
    task automatic walk_list(int steps, bit lead_restart);
        for (int k = 0; k < steps; k++)
            send_request((k == 0 && lead_restart) || $urandom_range(0, 59) == 0);
        end_requests();
    endtask

    // Picks a random setting. Most lists are short enough to be walked to
    // their end and sometimes a little past it; long ones are only walked in part.
    task automatic random_config(output int steps);
        int focal;
        int cx;
        int cy;
        int pairs;
        int count;

        case ($urandom_range(0, 9))
            0:       focal = ($urandom_range(0, 1) != 0) ? -4096 : 4095;
            1:       focal = $urandom_range(0, 8191) - 4096;
            2:       focal = 0;
            default: focal = $urandom_range(0, 12) - 6;
        endcase
        case ($urandom_range(0, 9))
            0:       pairs = ($urandom_range(0, 1) != 0) ? 0 : 4095;
            1:       pairs = $urandom_range(0, 4095);
            default: pairs = $urandom_range(1, 30);
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            cx = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
            cy = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
        end
        else
        begin
            cx = $urandom_range(0, 65535) - 32768;
            cy = $urandom_range(0, 65535) - 32768;
        end
        set_config(focal, cx, cy, pairs);
        count = 2 * pairs + 1;
        steps = (count <= 90) ? count + $urandom_range(0, 2) : $urandom_range(20, 80);
    endtask

    // Out of reset the list starts at the apex without a restart, using the
    // reset values of the registers.
    task automatic test_reset_defaults();
        idle_on = 1'b1;
        for (int k = 0; k < 4; k++)
            send_request(1'b0);
        end_requests();
    endtask

    // Register extremes, a zero focal length, the most negative focal length,
    // a list of the apex alone and requests past the end of the list.
    task automatic test_directed_corners();
        idle_on = 1'b1;
        set_config(0, 0, 0, 1);
        walk_list(0, 1'b0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        end_requests();

        set_config(-4096, 32767, -32768, 2);
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        end_requests();

        set_config(5, -1, 1, 0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        end_requests();

        set_config(4095, -32768, 32767, 4095);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        end_requests();
    endtask

    // Shrinking the list under a walk in progress makes the next request
    // exhausted; growing it again lets the old walk go on.
    task automatic test_midlist_config();
        idle_on = 1'b1;
        set_config(2, 100, -100, 3);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        end_requests();
        set_config(2, 100, -100, 1);
        send_request(1'b0);
        end_requests();
        set_config(-2, -7, 9, 3);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        end_requests();
    endtask

    // Mostly complete lists under random settings, some continuing a walk
    // begun under the previous setting.
    task automatic test_random_lists(int target);
        int steps;

        while (sent_count < target)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            random_config(steps);
            walk_list(steps, $urandom_range(0, 4) != 0);
        end
    endtask

    // The receiver holds off while requests keep coming, so both internal
    // stages fill and the request channel has to stall.
    task automatic test_backpressure();
        idle_on = 1'b0;
        set_config(3, 12, -34, 20);
        @(negedge clk);
        hold_req = HOLD_OFF;
        walk_list(20, 1'b1);
    endtask

    // Back-to-back beats on both sides to finish the run.
    task automatic test_unthrottled(int target);
        int steps;

        idle_on = 1'b0;
        while (sent_count < target)
        begin
            random_config(steps);
            walk_list(steps, $urandom_range(0, 4) != 0);
        end
    endtask

    // Receiver: random stall bursts, plus the long hold-off on request.
    initial
    begin
        int stall_left;
        int hold_left;

        stall_left  = 0;
        hold_left   = 0;
        pt_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pt_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pt_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                pt_ch.ready <= 1'b0;
            end
            else
                pt_ch.ready <= 1'b1;
        end
    end

    // Every point beat is checked against the oldest expected point.
    always @(posedge clk)
    begin
        point_t want;

        if (rst_n === 1'b1 && pt_ch.valid === 1'b1 && pt_ch.ready === 1'b1)
        begin
            if (pending_points.size() == 0)
                report_mismatch("point beat with no request waiting");
            else
            begin
                want = pending_points.pop_front();
                if (pt_ch.point_x !== want.x)
                    report_mismatch($sformatf("point_x got %0d want %0d",
                                              pt_ch.point_x, want.x));
                if (pt_ch.point_y !== want.y)
                    report_mismatch($sformatf("point_y got %0d want %0d",
                                              pt_ch.point_y, want.y));
                if (pt_ch.last_point !== want.last)
                    report_mismatch($sformatf("last_point got %b want %b",
                                              pt_ch.last_point, want.last));
                if (pt_ch.exhausted !== want.exhausted)
                    report_mismatch($sformatf("exhausted got %b want %b",
                                              pt_ch.exhausted, want.exhausted));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (pt_ch.valid === 1'b1 && pt_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        load_reset_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_corners();
        test_midlist_config();
        test_random_lists(1430);
        test_backpressure();
        test_unthrottled(1650);

        // Drain, then give a stray extra beat time to show up.
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mpp_pkg.sv
hdl/mpp_req_if.sv
hdl/mpp_pt_if.sv
hdl/mpp_cfg.sv
hdl/mpp_walk.sv
hdl/midpoint_parabola_points.sv
dv/tb_top.sv
